// File: design/spectral_section_nearest_lookup_top_assert.svh
// Assertion macros for the spectral section lookup checker.
// Needs signals named clock and reset in the module that uses them.
`ifndef SPECTRAL_SECTION_NEAREST_LOOKUP_TOP_ASSERT_SVH
`define SPECTRAL_SECTION_NEAREST_LOOKUP_TOP_ASSERT_SVH

// checked outside reset only
`define SSNL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define SSNL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/ssnl_pkg.sv
// Package for the spectral section lookup: sizes, codes, FSM states, buses.
// No dependencies.
package ssnl_pkg;

   localparam int MAX_SAMPLES  = 256;
   localparam int MAX_BANDS    = 256;
   localparam int MAX_SECTIONS = 16;

   // field widths as seen on the ports
   localparam int NUM_W    = 9;
   localparam int WL_W     = 32;
   localparam int SECT_W   = 4;
   localparam int TOTAL_W  = 5;
   localparam int STATUS_W = 2;
   localparam int MODE_W   = 2;

   localparam int SAMPLE_IDX_W = $clog2(MAX_SAMPLES);
   localparam int BAND_IDX_W   = $clog2(MAX_BANDS);
   localparam int ADDR_W       = SAMPLE_IDX_W + BAND_IDX_W;
   localparam int STORE_DEPTH  = MAX_SAMPLES * MAX_BANDS;
   localparam int ENTRY_W      = 2 * WL_W;

   localparam logic [NUM_W-1:0]   SAMPLE_LIMIT = NUM_W'(MAX_SAMPLES);
   localparam logic [NUM_W-1:0]   BAND_LIMIT   = NUM_W'(MAX_BANDS);
   localparam logic [TOTAL_W-1:0] SECT_LIMIT   = TOTAL_W'(MAX_SECTIONS);

   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SECTION = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SEARCH  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ_ISSUE,
      ST_READ_WAIT,
      ST_SECT_SCAN,
      ST_NEAR_LO,
      ST_NEAR_HI,
      ST_NEAR_SCAN,
      ST_DONE
   } state_type;

   // entry store access from the sequencer
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   // load of a sample-1 word into the section tracker
   typedef struct packed {
      logic             load;
      logic [NUM_W-1:0] band;
      logic [WL_W-1:0]  center;
   } sec_cmd_type;

   typedef struct packed {
      logic               full;
      logic [TOTAL_W-1:0] total;
   } sec_stat_type;

   function automatic logic [ADDR_W-1:0] entry_addr(input logic [NUM_W-1:0] sample,
                                                    input logic [NUM_W-1:0] band);
      logic [NUM_W-1:0] s0;
      logic [NUM_W-1:0] b0;
      s0 = sample - NUM_W'(1);
      b0 = band - NUM_W'(1);
      return {s0[SAMPLE_IDX_W-1:0], b0[BAND_IDX_W-1:0]};
   endfunction

endpackage

// File: design/spectral_section_nearest_lookup_top.sv
// Top level of the spectral section lookup: sequencer, entry store, section table.
// Depends on ssnl_pkg, ssnl_ctrl, ssnl_entry_ram, ssnl_section_table.
//
//  channel | ports       | handshake        | word
//  --------+-------------+------------------+----------------------------------
//  request | req_*       | req_valid/ready  | mode, sample, band, centre, width
//  result  | rsp_*       | rsp_valid/ready  | band, centre, width, section, ...
//  config  | csr_*       | csr_wr_en only   | bands_in_use, 9 bits
//
// One word in flight. A section query steps through the section starts and a
// nearest search through the bands of the section; out-of-range words go
// straight to the result register.
// The nearest search is bound by the single read port of the entry store:
// one band per cycle, pipelined as read, distance, compare.
// Reset is synchronous; it empties the result register and resets the section
// table to one section at band 1. The 64k-entry store is not cleared.
// A result waiting on rsp_ready holds the sequencer in its last state; the
// next request is taken as soon as the result moves into the output register.
module spectral_section_nearest_lookup_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ssnl_pkg::MODE_W-1:0]     req_mode,
   input  logic [ssnl_pkg::NUM_W-1:0]      req_sample_number,
   input  logic [ssnl_pkg::NUM_W-1:0]      req_band_number,
   input  logic [ssnl_pkg::WL_W-1:0]       req_center_wavelength,
   input  logic [ssnl_pkg::WL_W-1:0]       req_filter_width,
   input  logic [ssnl_pkg::SECT_W-1:0]     req_section_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ssnl_pkg::NUM_W-1:0]      rsp_found_band,
   output logic [ssnl_pkg::WL_W-1:0]       rsp_found_center,
   output logic [ssnl_pkg::WL_W-1:0]       rsp_found_width,
   output logic [ssnl_pkg::SECT_W-1:0]     rsp_section_found,
   output logic [ssnl_pkg::TOTAL_W-1:0]    rsp_sections_total,
   output logic [ssnl_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_wr_en,
   input  logic [ssnl_pkg::NUM_W-1:0]      csr_wr_data
);

   ssnl_pkg::ram_req_type          ram_req;
   logic [ssnl_pkg::ENTRY_W-1:0]   ram_rd_data;
   ssnl_pkg::sec_cmd_type          sec_cmd;
   logic [ssnl_pkg::SECT_W-1:0]    sec_rd_idx;
   logic [ssnl_pkg::NUM_W-1:0]     sec_rd_start;
   ssnl_pkg::sec_stat_type         sec_stat;

   // sequencer: owns the handshakes and the band count register
   ssnl_ctrl u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_sample_number     (req_sample_number),
      .req_band_number       (req_band_number),
      .req_center_wavelength (req_center_wavelength),
      .req_filter_width      (req_filter_width),
      .req_section_index     (req_section_index),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_found_band        (rsp_found_band),
      .rsp_found_center      (rsp_found_center),
      .rsp_found_width       (rsp_found_width),
      .rsp_section_found     (rsp_section_found),
      .rsp_sections_total    (rsp_sections_total),
      .rsp_status            (rsp_status),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .ram_req               (ram_req),
      .ram_rd_data           (ram_rd_data),
      .sec_cmd               (sec_cmd),
      .sec_rd_idx            (sec_rd_idx),
      .sec_rd_start          (sec_rd_start),
      .sec_stat              (sec_stat)
   );

   // centre/width per sample and band; the sequencer never reads and writes
   // in the same cycle, so no forwarding is needed
   ssnl_entry_ram u_entry_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   // section starts, count and the sample-1 turning point detector
   ssnl_section_table u_section_table (
      .clock    (clock),
      .reset    (reset),
      .sec_cmd  (sec_cmd),
      .rd_idx   (sec_rd_idx),
      .rd_start (sec_rd_start),
      .sec_stat (sec_stat)
   );

endmodule

// File: design/ssnl_entry_ram.sv
// Entry store: centre and width per sample and band, one write and one read port.
// Depends on ssnl_pkg. Read data registered, no reset.
module ssnl_entry_ram (
   input  logic                        clock,
   input  ssnl_pkg::ram_req_type       ram_req,
   output logic [ssnl_pkg::ENTRY_W-1:0] rd_data
);

   logic [ssnl_pkg::ENTRY_W-1:0] mem [ssnl_pkg::STORE_DEPTH];
   logic [ssnl_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ssnl_section_table.sv
// Section start table, section count and the two recent sample-1 centres.
// Depends on ssnl_pkg. One read port chosen by the sequencer.
module ssnl_section_table (
   input  logic                          clock,
   input  logic                          reset,
   input  ssnl_pkg::sec_cmd_type         sec_cmd,
   input  logic [ssnl_pkg::SECT_W-1:0]   rd_idx,
   output logic [ssnl_pkg::NUM_W-1:0]    rd_start,
   output ssnl_pkg::sec_stat_type        sec_stat
);

   logic [ssnl_pkg::NUM_W-1:0]   starts_ff [ssnl_pkg::MAX_SECTIONS];
   logic [ssnl_pkg::NUM_W-1:0]   starts_in [ssnl_pkg::MAX_SECTIONS];
   logic [ssnl_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic [ssnl_pkg::NUM_W-1:0]   last_ff, last_in;
   logic [ssnl_pkg::WL_W-1:0]    older_ff, older_in, newer_ff, newer_in;

   logic turn, open_sect, full;

   always_comb begin
      starts_in = starts_ff;
      total_in  = total_ff;
      last_in   = last_ff;
      older_in  = older_ff;
      newer_in  = newer_ff;

      // peak or valley over older, newer, current
      turn = ((older_ff < newer_ff) && (newer_ff > sec_cmd.center)) ||
             ((older_ff > newer_ff) && (newer_ff < sec_cmd.center));
      open_sect = sec_cmd.load && (sec_cmd.band >= ssnl_pkg::NUM_W'(3)) &&
                  ({1'b0, sec_cmd.band} != ({1'b0, last_ff} + 10'd1)) && turn;
      full = open_sect && (total_ff >= ssnl_pkg::SECT_LIMIT);

      if (sec_cmd.load) begin
         if (sec_cmd.band == ssnl_pkg::NUM_W'(1)) begin
            starts_in[0] = ssnl_pkg::NUM_W'(1);
            total_in     = ssnl_pkg::TOTAL_W'(1);
            last_in      = ssnl_pkg::NUM_W'(1);
         end else if (open_sect && !full) begin
            starts_in[total_ff[ssnl_pkg::SECT_W-1:0]] = sec_cmd.band;
            total_in = total_ff + ssnl_pkg::TOTAL_W'(1);
            last_in  = sec_cmd.band;
         end
         older_in = newer_ff;
         newer_in = sec_cmd.center;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ssnl_pkg::MAX_SECTIONS; i++) begin
            starts_ff[i] <= '0;
         end
         starts_ff[0] <= ssnl_pkg::NUM_W'(1);
         total_ff     <= ssnl_pkg::TOTAL_W'(1);
         last_ff      <= ssnl_pkg::NUM_W'(1);
         older_ff     <= '0;
         newer_ff     <= '0;
      end else begin
         starts_ff <= starts_in;
         total_ff  <= total_in;
         last_ff   <= last_in;
         older_ff  <= older_in;
         newer_ff  <= newer_in;
      end
   end

   assign rd_start       = starts_ff[rd_idx];
   assign sec_stat.full  = full;
   assign sec_stat.total = total_ff;

endmodule

// File: design/ssnl_ctrl.sv
// Sequencer: request capture, range checks, section scan, nearest search,
// response register and the band count register. Depends on ssnl_pkg.
module ssnl_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ssnl_pkg::MODE_W-1:0]     req_mode,
   input  logic [ssnl_pkg::NUM_W-1:0]      req_sample_number,
   input  logic [ssnl_pkg::NUM_W-1:0]      req_band_number,
   input  logic [ssnl_pkg::WL_W-1:0]       req_center_wavelength,
   input  logic [ssnl_pkg::WL_W-1:0]       req_filter_width,
   input  logic [ssnl_pkg::SECT_W-1:0]     req_section_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ssnl_pkg::NUM_W-1:0]      rsp_found_band,
   output logic [ssnl_pkg::WL_W-1:0]       rsp_found_center,
   output logic [ssnl_pkg::WL_W-1:0]       rsp_found_width,
   output logic [ssnl_pkg::SECT_W-1:0]     rsp_section_found,
   output logic [ssnl_pkg::TOTAL_W-1:0]    rsp_sections_total,
   output logic [ssnl_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                            csr_wr_en,
   input  logic [ssnl_pkg::NUM_W-1:0]      csr_wr_data,
   output ssnl_pkg::ram_req_type           ram_req,
   input  logic [ssnl_pkg::ENTRY_W-1:0]    ram_rd_data,
   output ssnl_pkg::sec_cmd_type           sec_cmd,
   output logic [ssnl_pkg::SECT_W-1:0]     sec_rd_idx,
   input  logic [ssnl_pkg::NUM_W-1:0]      sec_rd_start,
   input  ssnl_pkg::sec_stat_type          sec_stat
);

   localparam int NW = ssnl_pkg::NUM_W;
   localparam int WW = ssnl_pkg::WL_W;
   localparam int SW = ssnl_pkg::SECT_W;
   localparam int TW = ssnl_pkg::TOTAL_W;

   ssnl_pkg::state_type state_ff, state_in;

   logic [NW-1:0] bands_ff, bands_in;

   // captured request
   logic [NW-1:0] sample_ff, sample_in, band_ff, band_in;
   logic [WW-1:0] center_ff, center_in, width_ff, width_in;
   logic [SW-1:0] sect_ff, sect_in;

   // result being built
   logic [NW-1:0] res_band_ff, res_band_in;
   logic [WW-1:0] res_center_ff, res_center_in, res_width_ff, res_width_in;
   logic [SW-1:0] res_sect_ff, res_sect_in;
   logic [ssnl_pkg::STATUS_W-1:0] res_status_ff, res_status_in;

   // section scan
   logic [TW-1:0] idx_ff, idx_in;
   logic [NW-1:0] prev_ff, prev_in;
   logic          eq_found_ff, eq_found_in, iv_found_ff, iv_found_in;
   logic [SW-1:0] eq_idx_ff, eq_idx_in, iv_idx_ff, iv_idx_in;

   // nearest search pipeline
   logic [NW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [NW:0]   iss_ff, iss_in;
   logic          p1_valid_ff, p1_valid_in, p2_valid_ff, p2_valid_in;
   logic [NW-1:0] p1_band_ff, p1_band_in, p2_band_ff, p2_band_in;
   logic [WW-1:0] p2_diff_ff, p2_diff_in, p2_center_ff, p2_center_in;
   logic [WW-1:0] p2_width_ff, p2_width_in;
   logic          have_ff, have_in;
   logic [WW-1:0] best_ff, best_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0] rsp_band_ff, rsp_band_in;
   logic [WW-1:0] rsp_center_ff, rsp_center_in, rsp_width_ff, rsp_width_in;
   logic [SW-1:0] rsp_sect_ff, rsp_sect_in;
   logic [TW-1:0] rsp_total_ff, rsp_total_in;
   logic [ssnl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [NW-1:0] nb, hi_raw, hi_cl;
   logic          sample_ok, band_ok, issue;
   logic [WW-1:0] rd_center, rd_width;

   assign rd_center = ram_rd_data[ssnl_pkg::ENTRY_W-1:WW];
   assign rd_width  = ram_rd_data[WW-1:0];

   always_comb begin
      state_in      = state_ff;
      bands_in      = csr_wr_en ? csr_wr_data : bands_ff;
      sample_in     = sample_ff;
      band_in       = band_ff;
      center_in     = center_ff;
      width_in      = width_ff;
      sect_in       = sect_ff;
      res_band_in   = res_band_ff;
      res_center_in = res_center_ff;
      res_width_in  = res_width_ff;
      res_sect_in   = res_sect_ff;
      res_status_in = res_status_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      eq_found_in   = eq_found_ff;
      eq_idx_in     = eq_idx_ff;
      iv_found_in   = iv_found_ff;
      iv_idx_in     = iv_idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      iss_in        = iss_ff;
      p1_valid_in   = 1'b0;
      p1_band_in    = p1_band_ff;
      p2_valid_in   = 1'b0;
      p2_band_in    = p2_band_ff;
      p2_diff_in    = p2_diff_ff;
      p2_center_in  = p2_center_ff;
      p2_width_in   = p2_width_ff;
      have_in       = have_ff;
      best_in       = best_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_band_in   = rsp_band_ff;
      rsp_center_in = rsp_center_ff;
      rsp_width_in  = rsp_width_ff;
      rsp_sect_in   = rsp_sect_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;

      req_ready       = 1'b0;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = ssnl_pkg::entry_addr(sample_ff, band_ff);
      ram_req.wr_data = {center_ff, width_ff};
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = ssnl_pkg::entry_addr(sample_ff, band_ff);
      sec_cmd.load    = 1'b0;
      sec_cmd.band    = band_ff;
      sec_cmd.center  = center_ff;
      sec_rd_idx      = idx_ff[SW-1:0];
      issue           = 1'b0;
      hi_raw          = '0;
      hi_cl           = '0;

      // band count saturated to 1..MAX_BANDS
      if (bands_ff == '0) begin
         nb = NW'(1);
      end else if (bands_ff > ssnl_pkg::BAND_LIMIT) begin
         nb = ssnl_pkg::BAND_LIMIT;
      end else begin
         nb = bands_ff;
      end
      sample_ok = (req_sample_number != '0) && (req_sample_number <= ssnl_pkg::SAMPLE_LIMIT);
      band_ok   = (req_band_number != '0) && (req_band_number <= nb);

      case (state_ff)
         ssnl_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               sample_in     = req_sample_number;
               band_in       = req_band_number;
               center_in     = req_center_wavelength;
               width_in      = req_filter_width;
               sect_in       = req_section_index;
               res_band_in   = req_band_number;
               res_center_in = '0;
               res_width_in  = '0;
               res_sect_in   = '0;
               res_status_in = ssnl_pkg::STATUS_OK;
               idx_in        = '0;
               eq_found_in   = 1'b0;
               iv_found_in   = 1'b0;
               if ((req_mode != ssnl_pkg::MODE_SEARCH && !(sample_ok && band_ok)) ||
                   (req_mode == ssnl_pkg::MODE_SEARCH &&
                    (!sample_ok || {1'b0, req_section_index} >= sec_stat.total))) begin
                  res_band_in   = '0;
                  res_status_in = ssnl_pkg::STATUS_RANGE;
                  state_in      = ssnl_pkg::ST_DONE;
               end else begin
                  case (req_mode)
                     ssnl_pkg::MODE_LOAD:    state_in = ssnl_pkg::ST_LOAD;
                     ssnl_pkg::MODE_READ:    state_in = ssnl_pkg::ST_READ_ISSUE;
                     ssnl_pkg::MODE_SECTION: state_in = ssnl_pkg::ST_SECT_SCAN;
                     default:                state_in = ssnl_pkg::ST_NEAR_LO;
                  endcase
               end
            end
         end

         ssnl_pkg::ST_LOAD: begin
            ram_req.wr_en = 1'b1;
            sec_cmd.load  = (sample_ff == NW'(1));
            res_center_in = center_ff;
            res_width_in  = width_ff;
            res_status_in = sec_stat.full ? ssnl_pkg::STATUS_FULL : ssnl_pkg::STATUS_OK;
            state_in      = ssnl_pkg::ST_DONE;
         end

         ssnl_pkg::ST_READ_ISSUE: begin
            ram_req.rd_en = 1'b1;
            state_in      = ssnl_pkg::ST_READ_WAIT;
         end

         ssnl_pkg::ST_READ_WAIT: begin
            res_center_in = rd_center;
            res_width_in  = rd_width;
            state_in      = ssnl_pkg::ST_DONE;
         end

         ssnl_pkg::ST_SECT_SCAN: begin
            // one start per cycle; an exact match beats an enclosing pair
            if (idx_ff == sec_stat.total) begin
               if (eq_found_ff) begin
                  res_sect_in = eq_idx_ff;
               end else if (iv_found_ff) begin
                  res_sect_in = iv_idx_ff;
               end else begin
                  res_sect_in = SW'(sec_stat.total - TW'(1));
               end
               state_in = ssnl_pkg::ST_DONE;
            end else begin
               if (!eq_found_ff && sec_rd_start == band_ff) begin
                  eq_found_in = 1'b1;
                  eq_idx_in   = idx_ff[SW-1:0];
               end
               if (idx_ff != '0 && !iv_found_ff && prev_ff < band_ff &&
                   band_ff < sec_rd_start) begin
                  iv_found_in = 1'b1;
                  iv_idx_in   = idx_ff[SW-1:0] - SW'(1);
               end
               prev_in = sec_rd_start;
               idx_in  = idx_ff + TW'(1);
            end
         end

         ssnl_pkg::ST_NEAR_LO: begin
            sec_rd_idx = sect_ff;
            lo_in      = sec_rd_start;
            state_in   = ssnl_pkg::ST_NEAR_HI;
         end

         ssnl_pkg::ST_NEAR_HI: begin
            sec_rd_idx = sect_ff + SW'(1);
            if (({1'b0, sect_ff} + TW'(1)) == sec_stat.total) begin
               hi_raw = nb;
            end else begin
               hi_raw = sec_rd_start - NW'(1);
            end
            hi_cl = (hi_raw > nb) ? nb : hi_raw;
            // empty range: scan band 1 alone, which is then the answer
            if (lo_ff > hi_cl) begin
               iss_in = (NW + 1)'(1);
               hi_in  = NW'(1);
            end else begin
               iss_in = {1'b0, lo_ff};
               hi_in  = hi_cl;
            end
            have_in  = 1'b0;
            state_in = ssnl_pkg::ST_NEAR_SCAN;
         end

         ssnl_pkg::ST_NEAR_SCAN: begin
            // issue -> RAM data -> distance -> compare
            issue = (iss_ff <= {1'b0, hi_ff});
            if (issue) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ssnl_pkg::entry_addr(sample_ff, iss_ff[NW-1:0]);
               p1_valid_in     = 1'b1;
               p1_band_in      = iss_ff[NW-1:0];
               iss_in          = iss_ff + (NW + 1)'(1);
            end
            p2_valid_in  = p1_valid_ff;
            p2_band_in   = p1_band_ff;
            p2_center_in = rd_center;
            p2_width_in  = rd_width;
            p2_diff_in   = (rd_center >= center_ff) ? (rd_center - center_ff)
                                                    : (center_ff - rd_center);
            if (p2_valid_ff && (!have_ff || p2_diff_ff < best_ff)) begin
               have_in       = 1'b1;
               best_in       = p2_diff_ff;
               res_band_in   = p2_band_ff;
               res_center_in = p2_center_ff;
               res_width_in  = p2_width_ff;
            end
            if (!issue && !p1_valid_ff && !p2_valid_ff) begin
               res_sect_in = sect_ff;
               state_in    = ssnl_pkg::ST_DONE;
            end
         end

         ssnl_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_band_in   = res_band_ff;
               rsp_center_in = res_center_ff;
               rsp_width_in  = res_width_ff;
               rsp_sect_in   = res_sect_ff;
               rsp_total_in  = sec_stat.total;
               rsp_status_in = res_status_ff;
               state_in      = ssnl_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ssnl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssnl_pkg::ST_IDLE;
         bands_ff     <= ssnl_pkg::BAND_LIMIT;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         have_ff      <= 1'b0;
         eq_found_ff  <= 1'b0;
         iv_found_ff  <= 1'b0;
         idx_ff       <= '0;
         iss_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         bands_ff     <= bands_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         have_ff      <= have_in;
         eq_found_ff  <= eq_found_in;
         iv_found_ff  <= iv_found_in;
         idx_ff       <= idx_in;
         iss_ff       <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      band_ff       <= band_in;
      center_ff     <= center_in;
      width_ff      <= width_in;
      sect_ff       <= sect_in;
      res_band_ff   <= res_band_in;
      res_center_ff <= res_center_in;
      res_width_ff  <= res_width_in;
      res_sect_ff   <= res_sect_in;
      res_status_ff <= res_status_in;
      prev_ff       <= prev_in;
      eq_idx_ff     <= eq_idx_in;
      iv_idx_ff     <= iv_idx_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      p1_band_ff    <= p1_band_in;
      p2_band_ff    <= p2_band_in;
      p2_diff_ff    <= p2_diff_in;
      p2_center_ff  <= p2_center_in;
      p2_width_ff   <= p2_width_in;
      best_ff       <= best_in;
      rsp_band_ff   <= rsp_band_in;
      rsp_center_ff <= rsp_center_in;
      rsp_width_ff  <= rsp_width_in;
      rsp_sect_ff   <= rsp_sect_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found_band     = rsp_band_ff;
   assign rsp_found_center   = rsp_center_ff;
   assign rsp_found_width    = rsp_width_ff;
   assign rsp_section_found  = rsp_sect_ff;
   assign rsp_sections_total = rsp_total_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// File: design/ssnl_checker.sv
// Port-level checks on the spectral section lookup result channel.
// Depends on ssnl_pkg and the assertion macro header; bound to the top level.
`include "spectral_section_nearest_lookup_top_assert.svh"

module ssnl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [ssnl_pkg::NUM_W-1:0]      rsp_found_band,
   input logic [ssnl_pkg::WL_W-1:0]       rsp_found_center,
   input logic [ssnl_pkg::TOTAL_W-1:0]    rsp_sections_total,
   input logic [ssnl_pkg::STATUS_W-1:0]   rsp_status
);

   `SSNL_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "result valid after reset")

   `SSNL_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_band) && $stable(rsp_found_center), "stalled result changed")

   `SSNL_ASSERT(a_range_zero, rsp_valid && rsp_status == ssnl_pkg::STATUS_RANGE |-> rsp_found_band == '0 && rsp_found_center == '0, "range error with payload")

   `SSNL_ASSERT(a_full_total, rsp_valid && rsp_status == ssnl_pkg::STATUS_FULL |-> rsp_sections_total == ssnl_pkg::SECT_LIMIT, "table full below limit")

   `SSNL_ASSERT(a_total_range, rsp_valid |-> rsp_sections_total != '0 && rsp_sections_total <= ssnl_pkg::SECT_LIMIT, "section count out of range")

endmodule

bind spectral_section_nearest_lookup_top ssnl_checker u_checker (.*);

// File: tb/testbench.sv
// Self-checking bench for spectral_section_nearest_lookup_top: a queued driver
// and a checking monitor around its own predictor of the entry store, the
// section table and the nearest-band search. Depends on ssnl_pkg and design/.
module testbench;
   import ssnl_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_WORDS    = 95;
   localparam int PRINT_CAP      = 200;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [NUM_W-1:0]  sample_no;
      logic [NUM_W-1:0]  band_no;
      logic [WL_W-1:0]   centre;
      logic [WL_W-1:0]   width;
      logic [SECT_W-1:0] sect;
   } lookup_word_t;

   typedef struct {
      logic [NUM_W-1:0]    band;
      logic [WL_W-1:0]     centre;
      logic [WL_W-1:0]     width;
      logic [SECT_W-1:0]   sect;
      logic [TOTAL_W-1:0]  total;
      logic [STATUS_W-1:0] status;
   } answer_word_t;

   // ---------------------------------------------------------------- DUT I/O
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [NUM_W-1:0]    req_sample_number = '0;
   logic [NUM_W-1:0]    req_band_number = '0;
   logic [WL_W-1:0]     req_center_wavelength = '0;
   logic [WL_W-1:0]     req_filter_width = '0;
   logic [SECT_W-1:0]   req_section_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [NUM_W-1:0]    rsp_found_band;
   logic [WL_W-1:0]     rsp_found_center;
   logic [WL_W-1:0]     rsp_found_width;
   logic [SECT_W-1:0]   rsp_section_found;
   logic [TOTAL_W-1:0]  rsp_sections_total;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_wr_en = 1'b0;
   logic [NUM_W-1:0]    csr_wr_data = '0;

   spectral_section_nearest_lookup_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_mode              (req_mode),
      .req_sample_number     (req_sample_number),
      .req_band_number       (req_band_number),
      .req_center_wavelength (req_center_wavelength),
      .req_filter_width      (req_filter_width),
      .req_section_index     (req_section_index),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_found_band        (rsp_found_band),
      .rsp_found_center      (rsp_found_center),
      .rsp_found_width       (rsp_found_width),
      .rsp_section_found     (rsp_section_found),
      .rsp_sections_total    (rsp_sections_total),
      .rsp_status            (rsp_status),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------ predictor state
   // Shadow of the entry store, section table and the last two sample-1 centres.
   bit [WL_W-1:0]  store_centre [0:STORE_DEPTH-1];
   bit [WL_W-1:0]  store_width  [0:STORE_DEPTH-1];
   bit [NUM_W-1:0] sect_start   [0:MAX_SECTIONS-1] = '{0: 9'd1, default: 9'd0};
   int             sect_count = 1;
   bit [WL_W-1:0]  prev_centre  [0:1] = '{default: '0};
   bit [NUM_W-1:0] bands_cfg = 9'd256;

   lookup_word_t request_words [$];   // words still to be sent, head is on the bus
   answer_word_t due_answers   [$];   // predicted results, oldest first
   int           mismatches = 0;

   // stimulus-side bookkeeping: which entries hold data, recent centres
   bit             filled [0:STORE_DEPTH-1];
   int             filled_slots [$];
   bit [WL_W-1:0]  loaded_centres [$];
   bit [WL_W-1:0]  zz_centre = 32'h4000_0000;
   bit             zz_up = 1'b1;

   // bands_in_use as the block sees it, saturated into 1..MAX_BANDS
   function automatic int band_span();
      if (bands_cfg < 1) return 1;
      if (bands_cfg > MAX_BANDS) return MAX_BANDS;
      return int'(bands_cfg);
   endfunction

   function automatic int slot_of(input int s, input int b);
      return (s - 1) * MAX_BANDS + (b - 1);
   endfunction

   // Applies one accepted word to the shadow state and returns its result.
   function automatic answer_word_t predict_lookup(input lookup_word_t w);
      answer_word_t a;
      int           nb, addr, lo, hi, best, k;
      bit [WL_W-1:0] d, best_d, here;
      bit           sample_ok, band_ok, have, found, peak, valley;
      a = '{default: '0};
      nb = band_span();
      sample_ok = w.sample_no >= 1 && w.sample_no <= MAX_SAMPLES;
      band_ok = w.band_no >= 1 && w.band_no <= nb;
      if (w.mode != MODE_SEARCH && !(sample_ok && band_ok)) begin
         a.status = STATUS_RANGE;
      end else if (w.mode == MODE_LOAD) begin
         addr = slot_of(w.sample_no, w.band_no);
         store_centre[addr] = w.centre;
         store_width[addr] = w.width;
         if (w.sample_no == 1) begin
            if (w.band_no == 1) begin
               sect_start[0] = 9'd1;
               sect_count = 1;
            end else if (w.band_no >= 3 &&
                         int'(w.band_no) != int'(sect_start[sect_count-1]) + 1) begin
               peak = prev_centre[0] < prev_centre[1] && prev_centre[1] > w.centre;
               valley = prev_centre[0] > prev_centre[1] && prev_centre[1] < w.centre;
               if (peak || valley) begin
                  if (sect_count >= MAX_SECTIONS) begin
                     a.status = STATUS_FULL;
                  end else begin
                     sect_start[sect_count] = w.band_no;
                     sect_count++;
                  end
               end
            end
            prev_centre[0] = prev_centre[1];
            prev_centre[1] = w.centre;
         end
         a.band = w.band_no;
         a.centre = w.centre;
         a.width = w.width;
      end else if (w.mode == MODE_READ) begin
         addr = slot_of(w.sample_no, w.band_no);
         a.band = w.band_no;
         a.centre = store_centre[addr];
         a.width = store_width[addr];
      end else if (w.mode == MODE_SECTION) begin
         a.band = w.band_no;
         found = 1'b0;
         for (k = 0; k < sect_count; k++) begin
            if (!found && sect_start[k] == w.band_no) begin
               a.sect = SECT_W'(k);
               found = 1'b1;
            end
         end
         if (!found && sect_count > 1) begin
            for (k = 0; k + 1 < sect_count; k++) begin
               if (!found && w.band_no > sect_start[k] && w.band_no < sect_start[k+1]) begin
                  a.sect = SECT_W'(k);
                  found = 1'b1;
               end
            end
            if (!found) a.sect = SECT_W'(sect_count - 1);
         end
      end else begin
         if (!sample_ok || int'(w.sect) >= sect_count) begin
            a.status = STATUS_RANGE;
         end else begin
            // bands of the section, clipped to the band count; an empty range gives band 1
            lo = int'(sect_start[w.sect]) - 1;
            hi = (int'(w.sect) + 1 == sect_count) ? nb : int'(sect_start[w.sect+1]) - 1;
            if (hi > nb) hi = nb;
            best = 0;
            best_d = '0;
            have = 1'b0;
            for (k = lo; k < hi; k++) begin
               here = store_centre[slot_of(w.sample_no, k + 1)];
               d = (here >= w.centre) ? here - w.centre : w.centre - here;
               if (!have || d < best_d) begin
                  have = 1'b1;
                  best_d = d;
                  best = k;
               end
            end
            a.band = NUM_W'(best + 1);
            a.centre = store_centre[slot_of(w.sample_no, best + 1)];
            a.width = store_width[slot_of(w.sample_no, best + 1)];
            a.sect = w.sect;
         end
      end
      a.total = TOTAL_W'(sect_count);
      return a;
   endfunction

   // -------------------------------------------------------------- checking
   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) note_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // ------------------------------------------------------------- stimulus
   function automatic int bad_sample();
      return $urandom_range(1) ? 0 : $urandom_range(257, 511);
   endfunction

   function automatic int bad_band();
      return $urandom_range(1) ? 0 : $urandom_range(band_span() + 1, 511);
   endfunction

   function automatic void queue_word(input logic [MODE_W-1:0] mode, input int s, input int b,
                                      input logic [WL_W-1:0] c, input logic [WL_W-1:0] wd,
                                      input logic [SECT_W-1:0] k);
      lookup_word_t w;
      int           addr;
      w.mode = mode;
      w.sample_no = s[NUM_W-1:0];
      w.band_no = b[NUM_W-1:0];
      w.centre = c;
      w.width = wd;
      w.sect = k;
      request_words.push_back(w);
      if (mode == MODE_LOAD && s >= 1 && s <= MAX_SAMPLES && b >= 1 && b <= band_span()) begin
         addr = slot_of(s, b);
         if (!filled[addr]) begin
            filled[addr] = 1'b1;
            filled_slots.push_back(addr);
         end
         loaded_centres.push_back(c);
         if (loaded_centres.size() > 32) void'(loaded_centres.pop_front());
      end
   endfunction

   // zigzag walk of centres: runs up and down, with plateaus, rails and jumps
   function automatic bit [WL_W-1:0] next_centre(input int flip_pct);
      bit [WL_W-1:0] step;
      if ($urandom_range(99) < 8) begin
         zz_centre = $urandom();
      end else begin
         if ($urandom_range(99) < flip_pct) zz_up = !zz_up;
         step = ($urandom_range(9) == 0) ? '0 : $urandom_range(32'h00FF_FFFF, 1);
         if (zz_up) zz_centre = (zz_centre > 32'hFFFF_FFFF - step) ? '1 : zz_centre + step;
         else zz_centre = (zz_centre < step) ? '0 : zz_centre - step;
      end
      return zz_centre;
   endfunction

   // bands 1..last of one sample in order; on sample 1 this rebuilds the sections
   function automatic void queue_run(input int s, input int last, input int flip_pct);
      int b;
      for (b = 1; b <= last; b++)
         queue_word(MODE_LOAD, s, b, next_centre(flip_pct), $urandom(), SECT_W'($urandom()));
   endfunction

   // a search may only touch entries that hold data: bands 1..span of the sample
   function automatic bit search_safe(input int s);
      int b;
      if (s < 1 || s > MAX_SAMPLES) return 1'b1;
      for (b = 1; b <= band_span(); b++)
         if (!filled[slot_of(s, b)]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int queue_random_word();
      int pick, r, nb, s, b, last, addr;
      bit [WL_W-1:0] target;
      pick = $urandom_range(99);
      nb = band_span();
      r = $urandom_range(9);
      if (pick < 20) begin
         last = ($urandom_range(4) == 0) ? nb : $urandom_range(1, (nb < 40) ? nb : 40);
         queue_run(1, last, $urandom_range(10, 60));
         return last;
      end else if (pick < 35) begin
         if (r == 0) begin
            s = $urandom_range(1) ? bad_sample() : $urandom_range(1, MAX_SAMPLES);
            b = (s >= 1 && s <= MAX_SAMPLES) ? bad_band() : $urandom_range(0, 511);
         end else begin
            s = (r < 3) ? 1 : $urandom_range(2, MAX_SAMPLES);
            b = $urandom_range(1, nb);
         end
         queue_word(MODE_LOAD, s, b, next_centre(30), $urandom(), SECT_W'($urandom()));
      end else if (pick < 55) begin
         if (r < 8 && filled_slots.size() > 0) begin
            addr = filled_slots[$urandom_range(filled_slots.size() - 1)];
            s = addr / MAX_BANDS + 1;
            b = addr % MAX_BANDS + 1;
         end else if (r < 9) begin
            s = bad_sample();
            b = $urandom_range(0, 511);
         end else begin
            s = $urandom_range(1, MAX_SAMPLES);
            b = bad_band();
         end
         queue_word(MODE_READ, s, b, $urandom(), $urandom(), SECT_W'($urandom()));
      end else if (pick < 70) begin
         b = (r < 8) ? $urandom_range(0, nb + 2) : $urandom_range(0, 511);
         s = (r == 9) ? bad_sample() : $urandom_range(1, MAX_SAMPLES);
         queue_word(MODE_SECTION, s, b, $urandom(), $urandom(), SECT_W'($urandom()));
      end else begin
         s = (r < 5) ? 1 : (r < 8) ? MAX_SAMPLES : (r < 9) ? $urandom_range(2, 255) : bad_sample();
         if (!search_safe(s)) s = $urandom_range(257, 511);
         r = $urandom_range(9);
         if (r < 4 || loaded_centres.size() == 0) target = $urandom();
         else if (r < 7) target = loaded_centres[$urandom_range(loaded_centres.size() - 1)];
         else if (r < 8) target = '0;
         else if (r < 9) target = '1;
         else target = loaded_centres[$urandom_range(loaded_centres.size() - 1)] + $urandom_range(7);
         queue_word(MODE_SEARCH, s, $urandom_range(511), target, $urandom(),
                    SECT_W'(($urandom_range(9) < 6) ? $urandom_range(3) : $urandom_range(15)));
      end
      return 1;
   endfunction

   // ---------------------------------------------------------------- driver
   // Sends in bursts of random length with random gaps; a word stays on the
   // bus untouched until the block takes it.
   int burst_left = 1;
   int gap_left = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(9);
      if (r < 4) return 0;
      if (r < 8) return $urandom_range(1, 4);
      return $urandom_range(5, 30);
   endfunction

   always @(posedge clock) begin
      bit taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            due_answers.push_back(predict_lookup(request_words[0]));
            void'(request_words.pop_front());
         end
         if (!req_valid || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_words.size() > 0) begin
               req_valid <= 1'b1;
               req_mode <= request_words[0].mode;
               req_sample_number <= request_words[0].sample_no;
               req_band_number <= request_words[0].band_no;
               req_center_wavelength <= request_words[0].centre;
               req_filter_width <= request_words[0].width;
               req_section_index <= request_words[0].sect;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = pick_gap();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   // rsp_ready cycles through four patterns in turn: always ready,
   // one stall in four, coin toss, and long stretches of back-pressure.
   int rx_cycle = 0;

   always @(posedge clock) begin
      answer_word_t want;
      int           phase;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_answers.size() == 0) begin
               note_mismatch("result word with nothing predicted");
            end else begin
               want = due_answers.pop_front();
               check_field("found_band", 32'(rsp_found_band), 32'(want.band));
               check_field("found_center", rsp_found_center, want.centre);
               check_field("found_width", rsp_found_width, want.width);
               check_field("section_found", 32'(rsp_section_found), 32'(want.sect));
               check_field("sections_total", 32'(rsp_sections_total), 32'(want.total));
               check_field("status", 32'(rsp_status), 32'(want.status));
            end
         end
         rx_cycle++;
         phase = (rx_cycle / 700) % 4;
         case (phase)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= (rx_cycle % 4) != 0;
            end
            2: begin
               rsp_ready <= 1'($urandom_range(1));
            end
            default: begin
               rsp_ready <= (rx_cycle % 37) >= 15;
            end
         endcase
      end
   end

   // -------------------------------------------------------------- watchdog
   // Ends the run if nothing moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("spectral_section_nearest_lookup_top: mismatch");
      $finish;
   end

   // ------------------------------------------------------------- sequence
   // bands_in_use only changes while the block is idle
   task automatic set_bands(input int v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v[NUM_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      bands_cfg = v[NUM_W-1:0];
   endtask

   // every word sent and every result back, then a short pause
   task automatic settle();
      while (request_words.size() != 0 || due_answers.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   int bands_plan [9] = '{256, 1, 3, 0, 511, 2, 100, -1, 256};

   initial begin
      int n, p;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // Directed part with 8 bands: sections from two peaks, a valley on the
      // band just after a section start skipped, plateaus, range errors,
      // section queries and searches with a tie and an exact match.
      set_bands(8);
      queue_word(MODE_LOAD, 1, 1, 32'h1000_0000, 32'h0000_0000, 4'd0);
      queue_word(MODE_LOAD, 1, 2, 32'h2000_0000, 32'hFFFF_FFFF, 4'd0);
      queue_word(MODE_LOAD, 1, 3, 32'h1800_0000, 32'h1234_5678, 4'd0);   // peak
      queue_word(MODE_LOAD, 1, 4, 32'h3000_0000, 32'h0000_0001, 4'd0);   // valley, skipped
      queue_word(MODE_LOAD, 1, 5, 32'h0000_0000, 32'h8000_0000, 4'd0);   // peak
      queue_word(MODE_LOAD, 1, 6, 32'hFFFF_FFFF, 32'h0000_FFFF, 4'd0);   // skipped
      queue_word(MODE_LOAD, 1, 7, 32'hFFFF_FFFF, 32'hFFFF_0000, 4'd0);   // plateau
      queue_word(MODE_LOAD, 1, 8, 32'h0000_0000, 32'h5555_5555, 4'd0);
      queue_word(MODE_LOAD, 1, 9, 32'h0000_0001, 32'h0000_0001, 4'd0);   // band past count
      queue_word(MODE_LOAD, 0, 1, 32'h0000_0001, 32'h0000_0001, 4'd0);
      queue_word(MODE_LOAD, 511, 511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
      queue_word(MODE_READ, 1, 3, '0, '0, 4'd0);
      queue_word(MODE_READ, 1, 9, '0, '0, 4'd0);
      queue_word(MODE_READ, 257, 1, '0, '0, 4'd0);
      queue_word(MODE_SECTION, 1, 1, '0, '0, 4'd0);
      queue_word(MODE_SECTION, 1, 2, '0, '0, 4'd0);
      queue_word(MODE_SECTION, 1, 3, '0, '0, 4'd0);
      queue_word(MODE_SECTION, 1, 4, '0, '0, 4'd0);
      queue_word(MODE_SECTION, 1, 5, '0, '0, 4'd0);
      queue_word(MODE_SECTION, 1, 8, '0, '0, 4'd0);
      queue_word(MODE_SECTION, 1, 0, '0, '0, 4'd0);
      queue_word(MODE_SEARCH, 1, 0, 32'h1900_0000, '0, 4'd0);
      queue_word(MODE_SEARCH, 1, 0, 32'h0000_0000, '0, 4'd1);
      queue_word(MODE_SEARCH, 1, 0, 32'hFFFF_FFFF, '0, 4'd2);           // tie on 6 and 7
      queue_word(MODE_SEARCH, 1, 0, 32'h1800_0000, '0, 4'd3);           // no such section
      queue_word(MODE_SEARCH, 0, 0, 32'h1800_0000, '0, 4'd0);
      settle();

      // Random phases over several band counts. The first one fills samples 1
      // and 256 completely so that searches may run anywhere in them, and
      // forces a strict zigzag that overflows the section table.
      for (p = 0; p < 9; p++) begin
         set_bands((bands_plan[p] < 0) ? $urandom_range(4, 255) : bands_plan[p]);
         if (p == 0) begin
            queue_run(1, MAX_BANDS, 30);
            queue_run(MAX_SAMPLES, MAX_BANDS, 30);
            queue_run(1, 60, 100);
         end
         n = 0;
         while (n < PHASE_WORDS) n += queue_random_word();
         settle();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0 && due_answers.size() == 0) begin
         $display("spectral_section_nearest_lookup_top: match");
      end else begin
         $display("spectral_section_nearest_lookup_top: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/ssnl_pkg.sv
design/ssnl_entry_ram.sv
design/ssnl_section_table.sv
design/ssnl_ctrl.sv
design/spectral_section_nearest_lookup_top.sv
design/ssnl_checker.sv
tb/testbench.sv
